// ===== rtl/php_pkg.sv =====
package php_pkg;

  // Field widths fixed by the item format
  localparam int DATA_W      = 8;
  localparam int META_W      = 64;
  localparam int NUM_SLOTS   = 4;
  localparam int IN_TDATA_W  = DATA_W + NUM_SLOTS * META_W;
  localparam int OUT_TUSER_W = 2;

  // Configuration register widths
  localparam int CNT_W       = 3;
  localparam int SIZE_W      = 4;
  localparam int SLOT_IDX_W  = 2;
  localparam int BYTE_IDX_W  = 3;
  localparam int CFG_ADDR_W  = 6;
  localparam int CFG_DATA_W  = 64;
  localparam int REG_IDX_W   = 3;

  localparam logic [NUM_SLOTS*SIZE_W-1:0] SIZES_RESET = 16'h1111;

  // Byte queue between front and back
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_FIELD_COUNT = 3'd0,
    REG_FIELD_SIZES = 3'd1,
    REG_FROM_META   = 3'd2,
    REG_CONST_0     = 3'd3,
    REG_CONST_1     = 3'd4,
    REG_CONST_2     = 3'd5,
    REG_CONST_3     = 3'd6
  } reg_idx_t;

  // One queued beat, without its metadata words
  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic              first;
    logic              last;
    logic              hdr;
  } ctl_t;

  // Header settings seen by the back end
  typedef struct packed {
    logic [CNT_W-1:0]                   count;
    logic [NUM_SLOTS-1:0][SIZE_W-1:0]   sizes;
    logic [NUM_SLOTS-1:0]               from_meta;
    logic [NUM_SLOTS-1:0][META_W-1:0]   const_value;
  } cfg_t;

endpackage

// ===== rtl/packet_header_prepend_unit.sv =====
// Packet header prepend unit. Packet bytes enter on the s_ side one beat per
// byte; s_tuser marks the first byte of a packet and s_tlast the final one,
// and the four metadata words ride along in s_tdata (only the first byte's
// words are used). On a first byte the unit sends a header of up to four
// fields ahead of it: field i is 1..8 bytes long (nibble i of field_sizes,
// 0 read as 1), taken from const_value_i (most significant byte first) or
// from metadata word i (bits 7:0 first) as field_from_metadata selects.
// Each output beat carries one byte; m_tuser[0] marks the first byte of the
// encapsulated packet, m_tuser[1] the last beat caused by an input beat, and
// m_tlast the packet's final byte. The back-end sequencer drives one byte per
// cycle into the output register while the output is not stalled, so a
// first byte with a header goes out after all of its header bytes. A 4-beat
// queue sits between the input side and the sequencer, so input keeps
// flowing while header bytes go out or the output stalls. Registers sit at
// byte address 8*i on the configuration port; the user must write them only
// while the unit is idle, as the unit itself does not enforce it.
module packet_header_prepend_unit import php_pkg::*; #(
  parameter int MAX_FIELDS  = 4,
  parameter int FIELD_BYTES = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  // input beats
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [IN_TDATA_W-1:0]   s_tdata,   // data_byte, meta_word_0..3
  input  logic                    s_tuser,   // pkt_first
  input  logic                    s_tlast,   // pkt_last
  // output beats
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [DATA_W-1:0]       m_tdata,   // out_byte
  output logic [OUT_TUSER_W-1:0]  m_tuser,   // out_first, run_end
  output logic                    m_tlast,   // out_last
  // configuration port
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [CFG_ADDR_W-1:0]   paddr,
  input  logic [CFG_DATA_W-1:0]   pwdata,
  output logic [CFG_DATA_W-1:0]   prdata,
  output logic                    pready
);

  localparam int SLOTS_USED = (MAX_FIELDS < NUM_SLOTS) ? MAX_FIELDS : NUM_SLOTS;
  localparam int MW         = FIELD_BYTES * DATA_W;

  // Configuration registers
  logic [CNT_W-1:0]                 field_count;
  logic [NUM_SLOTS*SIZE_W-1:0]      field_sizes;
  logic [NUM_SLOTS-1:0]             field_from_metadata;
  logic [NUM_SLOTS-1:0][META_W-1:0] const_value;

  logic                             cfg_wr;
  logic [REG_IDX_W-1:0]             reg_idx;
  cfg_t                             cfg;

  logic [SLOTS_USED-1:0][MW-1:0]    s_meta;
  logic                             q_valid;
  ctl_t                             q_ctl;
  logic [SLOTS_USED-1:0][MW-1:0]    q_meta;
  logic                             q_pop;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[CFG_ADDR_W-1:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      field_count         <= '0;
      field_sizes         <= SIZES_RESET;
      field_from_metadata <= '0;
      const_value         <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_FIELD_COUNT: field_count         <= pwdata[CNT_W-1:0];
        REG_FIELD_SIZES: field_sizes         <= pwdata[NUM_SLOTS*SIZE_W-1:0];
        REG_FROM_META:   field_from_metadata <= pwdata[NUM_SLOTS-1:0];
        REG_CONST_0:     const_value[0]      <= pwdata;
        REG_CONST_1:     const_value[1]      <= pwdata;
        REG_CONST_2:     const_value[2]      <= pwdata;
        REG_CONST_3:     const_value[3]      <= pwdata;
        default:         ; // drop writes beyond the register list
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FIELD_COUNT: prdata = CFG_DATA_W'(field_count);
      REG_FIELD_SIZES: prdata = CFG_DATA_W'(field_sizes);
      REG_FROM_META:   prdata = CFG_DATA_W'(field_from_metadata);
      REG_CONST_0:     prdata = const_value[0];
      REG_CONST_1:     prdata = const_value[1];
      REG_CONST_2:     prdata = const_value[2];
      REG_CONST_3:     prdata = const_value[3];
      default:         prdata = '0;
    endcase
  end

  // Clamp the field count to the fields this build supports
  always_comb begin
    if (field_count > CNT_W'(SLOTS_USED)) begin
      cfg.count = CNT_W'(SLOTS_USED);
    end else begin
      cfg.count = field_count;
    end
    cfg.sizes       = field_sizes;
    cfg.from_meta   = field_from_metadata;
    cfg.const_value = const_value;
  end

  // Keep only the metadata bytes a field can reach
  for (genvar i = 0; i < SLOTS_USED; i++) begin : g_meta
    assign s_meta[i] = s_tdata[DATA_W + META_W*i +: MW];
  end

  php_front #(
    .SLOTS_USED (SLOTS_USED),
    .MW         (MW)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_data  (s_tdata[DATA_W-1:0]),
    .in_first (s_tuser),
    .in_last  (s_tlast),
    .in_meta  (s_meta),
    .count    (cfg.count),
    .q_valid  (q_valid),
    .q_ctl    (q_ctl),
    .q_meta   (q_meta),
    .q_pop    (q_pop)
  );

  php_back #(
    .SLOTS_USED  (SLOTS_USED),
    .FIELD_BYTES (FIELD_BYTES),
    .MW          (MW)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_valid     (q_valid),
    .q_ctl       (q_ctl),
    .q_meta      (q_meta),
    .q_pop       (q_pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_byte    (m_tdata),
    .out_first   (m_tuser[0]),
    .out_last    (m_tlast),
    .out_run_end (m_tuser[1])
  );

endmodule

// ===== rtl/php_front.sv =====
module php_front import php_pkg::*; #(
  parameter int SLOTS_USED = 4,
  parameter int MW         = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [DATA_W-1:0]                  in_data,
  input  logic                               in_first,
  input  logic                               in_last,
  input  logic [SLOTS_USED-1:0][MW-1:0]      in_meta,
  input  logic [CNT_W-1:0]                   count,
  output logic                               q_valid,
  output ctl_t                               q_ctl,
  output logic [SLOTS_USED-1:0][MW-1:0]      q_meta,
  input  logic                               q_pop
);

  ctl_t                               ctl_mem  [QDEPTH];
  logic [SLOTS_USED-1:0][MW-1:0]      meta_mem [QDEPTH];
  logic [QPTR_W-1:0]                  wr_ptr;
  logic [QPTR_W-1:0]                  rd_ptr;
  logic [QCNT_W-1:0]                  fill;
  logic                               push;
  ctl_t                               ctl_in;

  assign in_ready = (fill != QCNT_W'(QDEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (fill != '0);

  // Classify: a first byte with any field configured carries a header
  always_comb begin
    ctl_in.data  = in_data;
    ctl_in.first = in_first;
    ctl_in.last  = in_last;
    ctl_in.hdr   = in_first && (count != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, q_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ctl_mem[wr_ptr]  <= ctl_in;
      meta_mem[wr_ptr] <= in_meta;
    end
  end

  assign q_ctl  = ctl_mem[rd_ptr];
  assign q_meta = meta_mem[rd_ptr];

endmodule

// ===== rtl/php_back.sv =====
module php_back import php_pkg::*; #(
  parameter int SLOTS_USED  = 4,
  parameter int FIELD_BYTES = 8,
  parameter int MW          = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  cfg_t                               cfg,
  input  logic                               q_valid,
  input  ctl_t                               q_ctl,
  input  logic [SLOTS_USED-1:0][MW-1:0]      q_meta,
  output logic                               q_pop,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [DATA_W-1:0]                  out_byte,
  output logic                               out_first,
  output logic                               out_last,
  output logic                               out_run_end
);

  localparam int FI_W = (SLOTS_USED > 1) ? $clog2(SLOTS_USED) : 1;

  logic [FI_W-1:0]       fi;
  logic [BYTE_IDX_W-1:0] bi;
  logic                  hdr_done;

  logic                  hdr_phase;
  logic                  emit;
  logic [SLOT_IDX_W-1:0] slot;
  logic [SIZE_W-1:0]     sz_raw;
  logic [SIZE_W-1:0]     sz;
  logic [SIZE_W-1:0]     const_rev;
  logic                  byte_last;
  logic                  field_last;
  logic [DATA_W-1:0]     meta_byte;
  logic [DATA_W-1:0]     const_byte;
  logic [DATA_W-1:0]     hdr_byte;

  assign hdr_phase = q_valid && q_ctl.hdr && !hdr_done;
  assign emit      = q_valid && (!out_valid || out_ready);
  assign q_pop     = emit && !hdr_phase;

  assign slot   = SLOT_IDX_W'(fi);
  assign sz_raw = cfg.sizes[slot];

  // Clamp the field length to 1..FIELD_BYTES
  always_comb begin
    if (sz_raw == '0) begin
      sz = SIZE_W'(1);
    end else if (sz_raw > SIZE_W'(FIELD_BYTES)) begin
      sz = SIZE_W'(FIELD_BYTES);
    end else begin
      sz = sz_raw;
    end
  end

  assign const_rev  = sz - SIZE_W'(1) - SIZE_W'(bi);
  assign byte_last  = (SIZE_W'(bi) == sz - SIZE_W'(1));
  assign field_last = (CNT_W'(fi) == cfg.count - CNT_W'(1));

  // Metadata goes out low byte first, constants high byte first
  assign meta_byte  = DATA_W'(q_meta[fi] >> {bi, 3'b000});
  assign const_byte = DATA_W'(cfg.const_value[slot] >> {const_rev[BYTE_IDX_W-1:0], 3'b000});
  assign hdr_byte   = cfg.from_meta[slot] ? meta_byte : const_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      fi        <= '0;
      bi        <= '0;
      hdr_done  <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
        if (hdr_phase) begin
          if (byte_last) begin
            bi <= '0;
            if (field_last) begin
              fi       <= '0;
              hdr_done <= 1'b1;
            end else begin
              fi <= fi + 1'b1;
            end
          end else begin
            bi <= bi + 1'b1;
          end
        end else begin
          hdr_done <= 1'b0;
        end
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (hdr_phase) begin
        out_byte    <= hdr_byte;
        out_first   <= (fi == '0) && (bi == '0);
        out_last    <= 1'b0;
        out_run_end <= 1'b0;
      end else begin
        out_byte    <= q_ctl.data;
        out_first   <= q_ctl.first && !q_ctl.hdr;
        out_last    <= q_ctl.last;
        out_run_end <= 1'b1;
      end
    end
  end

endmodule

// ===== rtl/php_checker.sv =====
module php_checker import php_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [DATA_W-1:0]      m_tdata,
  input logic [OUT_TUSER_W-1:0] m_tuser,
  input logic                   m_tlast
);

  // Output side is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output beat valid after reset");

  // The packet's final byte is always the closing beat of its input byte
  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser[1])
    else $error("tlast on a header byte");

  // A header byte is never followed by another packet start
  a_no_restart_in_header: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tuser[1] |=> !(m_tvalid && m_tuser[0]))
    else $error("first mark inside a header run");

  // Stalled beat holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("output beat changed while stalled");

endmodule

bind packet_header_prepend_unit php_checker u_php_checker (.*);
